// ===== sv/ray_triangle_intersect_top_macros.svh =====
// Assertion macros for the ray/triangle intersection block.
// Included by the top level; empty when SYNTHESIS is defined.
`ifndef RAY_TRIANGLE_INTERSECT_TOP_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_TOP_MACROS_SVH
`ifndef SYNTHESIS
// antecedent true implies consequent in the same cycle
`define RTI_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rti assertion failed");
// antecedent true implies consequent in the next cycle
`define RTI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rti assertion failed");
`else
`define RTI_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define RTI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/rti_pkg.sv =====
// Types and constants shared by the ray/triangle intersection block.
// No dependencies.
package rti_pkg;

    localparam int W_CRD   = 32;   // coordinate width
    localparam int W_E     = 33;   // edge and offset vector width
    localparam int W_WIDE  = 104;  // determinant and numerator width
    localparam int W_C     = 31;   // normalised cross product component
    localparam int W_SS    = 64;   // sum of squares
    localparam int W_TQ    = 32;   // distance quotient, top bit flags overflow
    localparam int W_NQ    = 15;   // normal quotient
    localparam int W_NUM_N = 46;   // normal dividend
    localparam int W_LEN   = 32;   // normal length
    localparam int W_NRM   = 16;
    localparam int NRM_SHIFT = 14;
    localparam logic [W_NQ-1:0] NRM_ONE = 15'd16384;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 3'd5;

    typedef struct packed {
        logic signed [31:0] vert_a_x;
        logic signed [31:0] vert_a_y;
        logic signed [31:0] vert_a_z;
        logic signed [31:0] vert_b_x;
        logic signed [31:0] vert_b_y;
        logic signed [31:0] vert_b_z;
        logic signed [31:0] vert_c_x;
        logic signed [31:0] vert_c_y;
        logic signed [31:0] vert_c_z;
    } t_tri;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_distance;
        logic signed [31:0] hit_point_x;
        logic signed [31:0] hit_point_y;
        logic signed [31:0] hit_point_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } t_res;

    typedef struct packed {
        logic [2:0][W_CRD-1:0] org;
        logic [2:0][W_CRD-1:0] dir;
    } t_ray;

    // solver result handed to the dividers
    typedef struct packed {
        logic                 cand;
        logic [W_WIDE-1:0]    det;
        logic [W_WIDE-1:0]    nt;
        logic [W_SS-1:0]      ss;
        logic [2:0][W_C-1:0]  c;
        logic [2:0]           nsign;
    } t_sol;

    // travels beside the distance divider
    typedef struct packed {
        logic                 cand;
        logic [2:0][W_C-1:0]  c;
        logic [2:0]           nsign;
    } t_dsb;

    // travels beside the normal dividers
    typedef struct packed {
        logic                 hit;
        logic [W_CRD-1:0]     distance;
        logic [2:0][63:0]     prod;
        logic [2:0]           nsign;
    } t_nsb;

endpackage

// ===== sv/ray_triangle_intersect_top.sv =====
// Top level of the ray/triangle intersection block.
// Depends on rti_pkg, rti_solve, rti_pdiv, rti_isqrt and the macros header.
//
// Usage: load the ray through the write port (i_cfg_we, i_cfg_idx,
// i_cfg_data): origin x/y/z at indices 0..2, direction x/y/z at 3..5,
// signed fixed point with FRAC_BITS fraction bits. Writes to other indices
// are dropped. Change the ray only while no item is in flight.
// Triangles enter on i_valid/o_stall as i_tri; each gives exactly one
// result on o_valid/i_stall as o_res, in order.
// The pipeline is 8 solver stages, 32 stages of the distance divider
// (run beside a 32-stage square root for the normal length), one stage for
// the hit point product and divider set-up, 15 stages of the normal dividers
// and the output register. One item is taken every cycle while o_stall is low.
// The pipeline advances as a whole: while a result waits at the output and
// i_stall is high, every stage holds and o_stall is raised.
// Reset clears all valid bits and loads the ray origin (0,0,0) and
// direction (0,0,-1).
`include "ray_triangle_intersect_top_macros.svh"
module ray_triangle_intersect_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  rti_pkg::t_tri                  i_tri,
    output logic                           o_valid,
    input  logic                           i_stall,
    output rti_pkg::t_res                  o_res,
    input  logic                           i_cfg_we,
    input  logic [rti_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rti_pkg::W_CRD-1:0]      i_cfg_data
);
    import rti_pkg::*;

    localparam logic [W_CRD-1:0] MinusOne = ~((W_CRD'(1) << FRAC_BITS) - W_CRD'(1));
    localparam logic [W_CRD-1:0] DistMax  = {1'b0, {(W_CRD-1){1'b1}}};

    t_ray r_ray;
    logic en;

    logic  sol_vld;
    t_sol  sol;
    t_dsb  dsb_in, dsb;
    logic  dv_vld, sq_vld;
    logic [W_TQ-1:0]  dv_quo;
    logic [$bits(t_dsb)-1:0] dv_sb;
    logic [W_LEN-1:0] root;

    logic             n_x1_hit;
    logic [W_LEN-1:0] n_x1_len;
    t_nsb             n_x1_nsb, r_x1_nsb;
    logic             r_x1_vld;
    logic [W_NUM_N-1:0] n_x1_num [3];
    logic [W_NUM_N-1:0] r_x1_num [3];
    logic [W_LEN-1:0] r_x1_len;

    logic             nv_vld;
    logic [W_NQ-1:0]  nq [3];
    logic [$bits(t_nsb)-1:0] nsb_raw;
    t_nsb             nsb;

    logic signed [W_CRD-1:0] pt [3];
    logic signed [W_NRM-1:0] nrm [3];
    t_res n_out, r_out;
    logic r_out_vld;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray <= '{org: '0, dir: {MinusOne, {(2*W_CRD){1'b0}}}};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ORG_X: r_ray.org[0] <= i_cfg_data;
                REG_ORG_Y: r_ray.org[1] <= i_cfg_data;
                REG_ORG_Z: r_ray.org[2] <= i_cfg_data;
                REG_DIR_X: r_ray.dir[0] <= i_cfg_data;
                REG_DIR_Y: r_ray.dir[1] <= i_cfg_data;
                REG_DIR_Z: r_ray.dir[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // hold every stage while the result register is stalled
    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    rti_solve u_solve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_tri   (i_tri),
        .i_ray   (r_ray),
        .o_valid (sol_vld),
        .o_sol   (sol)
    );

    assign dsb_in.cand  = sol.cand;
    assign dsb_in.c     = sol.c;
    assign dsb_in.nsign = sol.nsign;

    rti_pdiv #(
        .NUM_W (W_WIDE + FRAC_BITS),
        .DEN_W (W_WIDE),
        .Q_W   (W_TQ),
        .SB_W  ($bits(t_dsb))
    ) u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sol_vld),
        .i_num   ({sol.nt, {FRAC_BITS{1'b0}}}),
        .i_den   (sol.det),
        .i_sb    (dsb_in),
        .o_valid (dv_vld),
        .o_quo   (dv_quo),
        .o_sb    (dv_sb)
    );

    rti_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sol_vld),
        .i_rad   (sol.ss),
        .o_valid (sq_vld),
        .o_root  (root)
    );

    assign dsb = t_dsb'(dv_sb);

    // distance, hit point product and normal divider set-up
    always_comb begin
        n_x1_hit      = dsb.cand && (dv_quo != '0);
        n_x1_nsb.hit  = n_x1_hit;
        if (!n_x1_hit) begin
            n_x1_nsb.distance = MinusOne;
        end else if (dv_quo[W_TQ-1]) begin
            n_x1_nsb.distance = DistMax;
        end else begin
            n_x1_nsb.distance = {1'b0, dv_quo[W_TQ-2:0]};
        end
        for (int i = 0; i < 3; i++) begin
            n_x1_nsb.prod[i] = $signed(n_x1_nsb.distance) * $signed(r_ray.dir[i]);
        end
        n_x1_nsb.nsign = dsb.nsign;
        n_x1_len = (root == '0) ? W_LEN'(1) : root;
        for (int i = 0; i < 3; i++) begin
            n_x1_num[i] = (W_NUM_N'(dsb.c[i]) << NRM_SHIFT) + W_NUM_N'(n_x1_len[W_LEN-1:1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1_vld <= 1'b0;
        end else if (en) begin
            r_x1_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x1_nsb <= n_x1_nsb;
            r_x1_num <= n_x1_num;
            r_x1_len <= n_x1_len;
        end
    end

    rti_pdiv #(
        .NUM_W (W_NUM_N),
        .DEN_W (W_LEN),
        .Q_W   (W_NQ),
        .SB_W  ($bits(t_nsb))
    ) u_ndiv0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_x1_vld),
        .i_num   (r_x1_num[0]),
        .i_den   (r_x1_len),
        .i_sb    (r_x1_nsb),
        .o_valid (nv_vld),
        .o_quo   (nq[0]),
        .o_sb    (nsb_raw)
    );

    for (genvar gi = 1; gi < 3; gi++) begin : g_ndiv
        rti_pdiv #(
            .NUM_W (W_NUM_N),
            .DEN_W (W_LEN),
            .Q_W   (W_NQ),
            .SB_W  (1)
        ) u_ndiv (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r_x1_vld),
            .i_num   (r_x1_num[gi]),
            .i_den   (r_x1_len),
            .i_sb    (1'b0),
            .o_valid (),
            .o_quo   (nq[gi]),
            .o_sb    ()
        );
    end

    assign nsb = t_nsb'(nsb_raw);

    // hit point with saturation, signed normal components
    always_comb begin
        logic signed [63:0]      step;
        logic signed [W_CRD:0]   wide_sum;
        logic signed [64:0]      sum;
        logic [W_NQ-1:0]         nc;
        for (int i = 0; i < 3; i++) begin
            step = $signed(nsb.prod[i]) >>> FRAC_BITS;
            sum  = 65'($signed(r_ray.org[i])) + 65'(step);
            wide_sum = '0;
            if (sum > 65'sd2147483647) begin
                pt[i] = $signed(DistMax);
            end else if (sum < -65'sd2147483648) begin
                pt[i] = $signed(~DistMax);
            end else begin
                wide_sum = sum[W_CRD:0];
                pt[i] = wide_sum[W_CRD-1:0];
            end
            nc = (nq[i] > NRM_ONE) ? NRM_ONE : nq[i];
            nrm[i] = nsb.nsign[i] ? -W_NRM'(nc) : W_NRM'(nc);
        end
        n_out.hit          = nsb.hit;
        n_out.hit_distance = nsb.distance;
        n_out.hit_point_x  = nsb.hit ? pt[0] : '0;
        n_out.hit_point_y  = nsb.hit ? pt[1] : '0;
        n_out.hit_point_z  = nsb.hit ? pt[2] : '0;
        n_out.normal_x     = nsb.hit ? nrm[0] : '0;
        n_out.normal_y     = nsb.hit ? nrm[1] : '0;
        n_out.normal_z     = nsb.hit ? nrm[2] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= nv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_out;

    `RTI_ASSERT_IMPLY(a_div_sqrt_lockstep, i_clk, i_rst_n, 1'b1, dv_vld == sq_vld)
    `RTI_ASSERT_IMPLY(a_hit_dist_positive, i_clk, i_rst_n, r_out_vld && r_out.hit, !r_out.hit_distance[W_CRD-1] && (r_out.hit_distance != '0))
    `RTI_ASSERT_IMPLY(a_miss_clean, i_clk, i_rst_n, r_out_vld && !r_out.hit, (r_out.hit_distance == MinusOne) && (r_out.normal_x == '0) && (r_out.hit_point_x == '0))
    `RTI_ASSERT_IMPLY(a_normal_bounded, i_clk, i_rst_n, nv_vld && nsb.hit, (nq[0] <= NRM_ONE) && (nq[1] <= NRM_ONE) && (nq[2] <= NRM_ONE))
    `RTI_ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n, r_out_vld && i_stall, r_out_vld && $stable(r_x1_vld))
endmodule

// ===== sv/rti_pdiv.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on nothing.
module rti_pdiv #(
    parameter int NUM_W = 46,
    parameter int DEN_W = 32,
    parameter int Q_W   = 15,
    parameter int SB_W  = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [SB_W-1:0]  i_sb,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_quo,
    output logic [SB_W-1:0]  o_sb
);
    localparam int IW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic             r_vld [Q_W];
    logic [IW-1:0]    r_rem [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];
    logic [SB_W-1:0]  r_sb  [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int SH = Q_W - 1 - k;
        logic             v_in;
        logic [IW-1:0]    rem_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   quo_in;
        logic [SB_W-1:0]  sb_in;
        logic [IW-1:0]    den_sh;
        logic             take;
        logic [IW-1:0]    n_rem;
        logic [Q_W-1:0]   n_quo;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = IW'(i_num);
            assign den_in = i_den;
            assign quo_in = '0;
            assign sb_in  = i_sb;
        end else begin : g_next
            assign v_in   = r_vld[k-1];
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
            assign sb_in  = r_sb[k-1];
        end

        assign den_sh = IW'(den_in) << SH;
        assign take   = rem_in >= den_sh;
        assign n_rem  = take ? rem_in - den_sh : rem_in;
        assign n_quo  = {quo_in[Q_W-2:0], take};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= den_in;
                r_quo[k] <= n_quo;
                r_sb[k]  <= sb_in;
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quo   = r_quo[Q_W-1];
    assign o_sb    = r_sb[Q_W-1];
endmodule

// ===== sv/rti_isqrt.sv =====
// Pipelined integer square root of the 64-bit sum of squares, two bits a stage.
// Depends on rti_pkg.
module rti_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [rti_pkg::W_SS-1:0]    i_rad,
    output logic                        o_valid,
    output logic [rti_pkg::W_LEN-1:0]   o_root
);
    import rti_pkg::*;

    localparam int NST = W_SS / 2;

    logic            r_vld [NST];
    logic [W_SS-1:0] r_x   [NST];
    logic [W_SS-1:0] r_res [NST];

    for (genvar k = 0; k < NST; k++) begin : g_stage
        localparam int BP = W_SS - 2 - 2 * k;
        logic            v_in;
        logic [W_SS-1:0] x_in;
        logic [W_SS-1:0] res_in;
        logic [W_SS-1:0] bit_k;
        logic [W_SS:0]   trial;
        logic            take;
        logic [W_SS-1:0] n_x;
        logic [W_SS-1:0] n_res;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign x_in   = i_rad;
            assign res_in = '0;
        end else begin : g_next
            assign v_in   = r_vld[k-1];
            assign x_in   = r_x[k-1];
            assign res_in = r_res[k-1];
        end

        assign bit_k = W_SS'(1) << BP;
        assign trial = {1'b0, res_in} + {1'b0, bit_k};
        assign take  = {1'b0, x_in} >= trial;
        assign n_x   = take ? x_in - trial[W_SS-1:0] : x_in;
        assign n_res = take ? (res_in >> 1) + bit_k : res_in >> 1;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]   <= n_x;
                r_res[k] <= n_res;
            end
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_root  = r_res[NST-1][W_LEN-1:0];
endmodule

// ===== sv/rti_solve.sv =====
// Eight-stage Cramer solver: edges, cross products, the four dot products
// and the hit tests, plus the normalised face normal components. Uses rti_pkg.
module rti_solve (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  rti_pkg::t_tri   i_tri,
    input  rti_pkg::t_ray   i_ray,
    output logic            o_valid,
    output rti_pkg::t_sol   o_sol
);
    import rti_pkg::*;

    localparam int WX = 67;  // cross product width
    localparam int SPL = 34; // split point for the wide dot operands

    logic [8:1] r_vld;

    logic signed [W_CRD-1:0] va [3];
    logic signed [W_CRD-1:0] vb [3];
    logic signed [W_CRD-1:0] vc [3];

    logic signed [W_E-1:0]   r1_e1 [3], r1_e2 [3], r1_s [3];
    logic signed [W_CRD-1:0] r1_d  [3];
    logic signed [W_E-1:0]   r2_e1 [3], r2_e2 [3], r2_s [3];
    logic signed [W_CRD-1:0] r2_d  [3];
    logic signed [64:0]      r2_pp [3], r2_pm [3];
    logic signed [65:0]      r2_qp [3], r2_qm [3], r2_np [3], r2_nm [3];
    logic signed [W_E-1:0]   r3_e1 [3], r3_e2 [3], r3_s [3];
    logic signed [W_CRD-1:0] r3_d  [3];
    logic signed [WX-1:0]    r3_p  [3], r3_q [3], r3_n [3];

    logic signed [W_E-1:0]   a4 [4][3];
    logic signed [WX-1:0]    w4 [4][3];
    logic signed [67:0]      r4_lo [4][3];
    logic signed [65:0]      r4_hi [4][3];
    logic [WX-1:0]           r4_mag [3];
    logic [2:0]              r4_nsg;

    logic signed [W_WIDE-1:0] r5_term [4][3];
    logic [WX-1:0]            n5_mag [3], r5_mag [3];
    logic [2:0]               r5_nsg;

    logic signed [W_WIDE-1:0] r6_dot [4];
    logic [WX-1:0]            n6_mag [3];
    logic [W_C-1:0]           r6_c [3];
    logic [2:0]               r6_nsg;

    logic signed [W_WIDE-1:0] r7_dot [4];
    logic [2*W_C-1:0]         r7_sq [3];
    logic [W_C-1:0]           r7_c [3];
    logic [2:0]               r7_nsg;

    t_sol n8_sol, r8_sol;

    assign va[0] = i_tri.vert_a_x;
    assign va[1] = i_tri.vert_a_y;
    assign va[2] = i_tri.vert_a_z;
    assign vb[0] = i_tri.vert_b_x;
    assign vb[1] = i_tri.vert_b_y;
    assign vb[2] = i_tri.vert_b_z;
    assign vc[0] = i_tri.vert_c_x;
    assign vc[1] = i_tri.vert_c_y;
    assign vc[2] = i_tri.vert_c_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[7:1], i_valid};
        end
    end

    // stage 1: edges and origin offset
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_e1[i] <= W_E'(vb[i]) - W_E'(va[i]);
                r1_e2[i] <= W_E'(vc[i]) - W_E'(va[i]);
                r1_s[i]  <= W_E'($signed(i_ray.org[i])) - W_E'(va[i]);
                r1_d[i]  <= $signed(i_ray.dir[i]);
            end
        end
    end

    // stage 2: cross product terms
    for (genvar gi = 0; gi < 3; gi++) begin : g_cross
        localparam int J = (gi + 1) % 3;
        localparam int K = (gi + 2) % 3;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r2_pp[gi] <= r1_d[J] * r1_e2[K];
                r2_pm[gi] <= r1_d[K] * r1_e2[J];
                r2_qp[gi] <= r1_s[J] * r1_e1[K];
                r2_qm[gi] <= r1_s[K] * r1_e1[J];
                r2_np[gi] <= r1_e1[J] * r1_e2[K];
                r2_nm[gi] <= r1_e1[K] * r1_e2[J];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_e1 <= r1_e1;
            r2_e2 <= r1_e2;
            r2_s  <= r1_s;
            r2_d  <= r1_d;
        end
    end

    // stage 3: P = D x E2, Q = S x E1, N = E1 x E2
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r3_p[i] <= WX'(r2_pp[i]) - WX'(r2_pm[i]);
                r3_q[i] <= WX'(r2_qp[i]) - WX'(r2_qm[i]);
                r3_n[i] <= WX'(r2_np[i]) - WX'(r2_nm[i]);
            end
            r3_e1 <= r2_e1;
            r3_e2 <= r2_e2;
            r3_s  <= r2_s;
            r3_d  <= r2_d;
        end
    end

    // stage 4: dot product partial products, wide operand split in two
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a4[0][i] = r3_e1[i];
            w4[0][i] = r3_p[i];
            a4[1][i] = r3_s[i];
            w4[1][i] = r3_p[i];
            a4[2][i] = W_E'(r3_d[i]);
            w4[2][i] = r3_q[i];
            a4[3][i] = r3_e2[i];
            w4[3][i] = r3_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int m = 0; m < 4; m++) begin
                for (int i = 0; i < 3; i++) begin
                    r4_lo[m][i] <= a4[m][i] * $signed({1'b0, w4[m][i][SPL-1:0]});
                    r4_hi[m][i] <= a4[m][i] * $signed(w4[m][i][WX-1:SPL]);
                end
            end
            for (int i = 0; i < 3; i++) begin
                r4_mag[i] <= r3_n[i][WX-1] ? WX'(-r3_n[i]) : WX'(r3_n[i]);
                r4_nsg[i] <= r3_n[i][WX-1];
            end
        end
    end

    // normal: bring the largest magnitude below 2^31 by a common right shift
    always_comb begin
        n5_mag = r4_mag;
        for (int st = 0; st < 3; st++) begin
            if (((n5_mag[0] | n5_mag[1] | n5_mag[2]) >> (W_C - 1 + (32 >> st))) != '0) begin
                for (int i = 0; i < 3; i++) begin
                    n5_mag[i] = n5_mag[i] >> (32 >> st);
                end
            end
        end
    end

    always_comb begin
        n6_mag = r5_mag;
        for (int st = 0; st < 3; st++) begin
            if (((n6_mag[0] | n6_mag[1] | n6_mag[2]) >> (W_C - 1 + (4 >> st))) != '0) begin
                for (int i = 0; i < 3; i++) begin
                    n6_mag[i] = n6_mag[i] >> (4 >> st);
                end
            end
        end
    end

    // stage 5: recombine partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int m = 0; m < 4; m++) begin
                for (int i = 0; i < 3; i++) begin
                    r5_term[m][i] <= (W_WIDE'(r4_hi[m][i]) <<< SPL) + W_WIDE'(r4_lo[m][i]);
                end
            end
            r5_mag <= n5_mag;
            r5_nsg <= r4_nsg;
        end
    end

    // stage 6: sum the dot products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int m = 0; m < 4; m++) begin
                r6_dot[m] <= r5_term[m][0] + r5_term[m][1] + r5_term[m][2];
            end
            for (int i = 0; i < 3; i++) begin
                r6_c[i] <= n6_mag[i][W_C-1:0];
            end
            r6_nsg <= r5_nsg;
        end
    end

    // stage 7: make the determinant positive, square the normal components
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int m = 0; m < 4; m++) begin
                r7_dot[m] <= r6_dot[0][W_WIDE-1] ? -r6_dot[m] : r6_dot[m];
            end
            for (int i = 0; i < 3; i++) begin
                r7_sq[i] <= r6_c[i] * r6_c[i];
            end
            r7_c   <= r6_c;
            r7_nsg <= r6_nsg;
        end
    end

    // stage 8: inside-triangle tests
    always_comb begin
        n8_sol.cand = (r7_dot[0] != '0) && !r7_dot[1][W_WIDE-1] && !r7_dot[2][W_WIDE-1]
                      && !r7_dot[3][W_WIDE-1] && (r7_dot[0] >= r7_dot[1] + r7_dot[2]);
        n8_sol.det  = r7_dot[0];
        n8_sol.nt   = r7_dot[3];
        n8_sol.ss   = W_SS'(r7_sq[0]) + W_SS'(r7_sq[1]) + W_SS'(r7_sq[2]);
        for (int i = 0; i < 3; i++) begin
            n8_sol.c[i] = r7_c[i];
        end
        n8_sol.nsign = r7_nsg;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r8_sol <= n8_sol;
        end
    end

    assign o_valid = r_vld[8];
    assign o_sol   = r8_sol;
endmodule
